FILE: design/fecu_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fecu_pkg
// Shared types, constants and palette functions of the fire cell updater.
// ----------------------------------------------------------------------------
package fecu_pkg;

  localparam int unsigned MaxWidth   = 256;
  localparam int unsigned MaxHeight  = 128;
  localparam int unsigned StoreDepth = MaxWidth * MaxHeight;
  localparam int unsigned AddrW      = $clog2(StoreDepth);
  localparam int unsigned WidthW     = 9;
  localparam int unsigned HeightW    = 8;
  localparam int unsigned ColW       = $clog2(MaxWidth);
  localparam int unsigned RowW       = $clog2(MaxHeight);
  localparam int unsigned HeatW      = 4;
  localparam int unsigned GlyphW     = 14;
  localparam int unsigned ColorW     = 8;
  localparam int unsigned PickW      = 2;

  localparam logic [HeatW-1:0]   HeatMax      = HeatW'(12);
  localparam logic [WidthW-1:0]  WidthReset   = WidthW'(80);
  localparam logic [HeightW-1:0] HeightReset  = HeightW'(24);
  localparam logic [WidthW-1:0]  WidthLimit   = WidthW'(MaxWidth);
  localparam logic [HeightW-1:0] HeightLimit  = HeightW'(MaxHeight);
  localparam logic [HeightW-1:0] HeightFloor  = HeightW'(2);

  localparam logic [GlyphW-1:0] GlyphSpace = GlyphW'(32);
  localparam logic [GlyphW-1:0] GlyphLight = GlyphW'(16'h2591);
  localparam logic [GlyphW-1:0] GlyphMid   = GlyphW'(16'h2592);
  localparam logic [GlyphW-1:0] GlyphDark  = GlyphW'(16'h2593);
  localparam logic [GlyphW-1:0] GlyphFull  = GlyphW'(16'h2588);

  localparam logic [ColorW-1:0] ColBlack  = ColorW'(0);
  localparam logic [ColorW-1:0] ColGrey   = ColorW'(16);
  localparam logic [ColorW-1:0] ColRed    = ColorW'(5 * 6 * 6);
  localparam logic [ColorW-1:0] ColOrange = ColorW'(210);
  localparam logic [ColorW-1:0] ColYellow = ColorW'(215);

  typedef enum logic {
    REG_FRAME_WIDTH  = 1'b0,
    REG_FRAME_HEIGHT = 1'b1
  } reg_idx_e;

  // effective geometry and clearing status
  typedef struct packed {
    logic [WidthW-1:0]  width;
    logic [HeightW-1:0] height;
    logic               clearing;
  } cfg_t;

  // one write into the heat memory
  typedef struct packed {
    logic             en;
    logic [AddrW-1:0] addr;
    logic [HeatW-1:0] heat;
  } heat_wr_t;

  // one scanned cell, ready to enter the update stage
  typedef struct packed {
    logic [AddrW-1:0] src;
    logic [AddrW-1:0] dst;
    logic             done;
  } scan_item_t;

  function automatic logic [GlyphW-1:0] pal_glyph(input logic [HeatW-1:0] heat);
    logic [GlyphW-1:0] g;
    g = GlyphSpace;
    case (heat) inside
      4'd1, 4'd5, 4'd9:  g = GlyphLight;
      4'd2, 4'd6, 4'd10: g = GlyphMid;
      4'd3, 4'd7, 4'd11: g = GlyphDark;
      4'd4, 4'd8, 4'd12: g = GlyphFull;
      default:           g = GlyphSpace;
    endcase
    return g;
  endfunction

  function automatic logic [ColorW-1:0] pal_fg(input logic [HeatW-1:0] heat);
    logic [ColorW-1:0] c;
    c = ColGrey;
    case (heat) inside
      [4'd1:4'd4]:  c = ColRed;
      [4'd5:4'd8]:  c = ColOrange;
      [4'd9:4'd12]: c = ColYellow;
      default:      c = ColGrey;
    endcase
    return c;
  endfunction

  function automatic logic [ColorW-1:0] pal_bg(input logic [HeatW-1:0] heat);
    logic [ColorW-1:0] c;
    c = ColBlack;
    case (heat) inside
      [4'd5:4'd8]:  c = ColRed;
      [4'd9:4'd12]: c = ColOrange;
      default:      c = ColBlack;
    endcase
    return c;
  endfunction

endpackage

FILE: design/fecu_heat_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fecu_heat_ram
// Heat map storage: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module fecu_heat_ram
  import fecu_pkg::*;
(
  input  logic             clk_i,
  input  heat_wr_t         wr_i,
  input  logic             rd_en_i,
  input  logic [AddrW-1:0] rd_addr_i,
  output logic [HeatW-1:0] rd_data_o
);

  logic [HeatW-1:0] mem_q [StoreDepth];

  always_ff @(posedge clk_i) begin
    if (wr_i.en) begin
      mem_q[wr_i.addr] <= wr_i.heat;
    end
  end

  // read returns the old contents on a same-cycle write
  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data_o <= mem_q[rd_addr_i];
    end
  end

endmodule

FILE: design/fecu_cfg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fecu_cfg
// Register port for the frame geometry and the map clearing sweep.
// ----------------------------------------------------------------------------
module fecu_cfg
  import fecu_pkg::*;
(
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         psel,
  input  logic         penable,
  input  logic         pwrite,
  input  logic [2:0]   paddr,
  input  logic [31:0]  pwdata,
  output logic [31:0]  prdata,
  output logic         pready,
  output cfg_t         cfg_o,
  output heat_wr_t     clr_o
);

  logic [WidthW-1:0]  width_q;
  logic [HeightW-1:0] height_q;
  logic [WidthW-1:0]  width_eff;
  logic [HeightW-1:0] height_eff;
  logic               clr_active_q;
  logic [AddrW-1:0]   clr_addr_q;
  logic [AddrW-1:0]   base_q;
  logic [AddrW:0]     top;
  logic               wr_fire;
  reg_idx_e           wr_idx;
  logic               in_bottom;

  assign pready  = 1'b1;
  assign wr_fire = psel && penable && pwrite;
  assign wr_idx  = reg_idx_e'(paddr[2]);

  always_comb begin
    case (reg_idx_e'(paddr[2]))
      REG_FRAME_WIDTH:  prdata = {{(32-WidthW){1'b0}}, width_q};
      REG_FRAME_HEIGHT: prdata = {{(32-HeightW){1'b0}}, height_q};
      default:          prdata = '0;
    endcase
  end

  // saturate the geometry
  always_comb begin
    if (width_q == '0) begin
      width_eff = WidthW'(1);
    end else if (width_q > WidthLimit) begin
      width_eff = WidthLimit;
    end else begin
      width_eff = width_q;
    end
    if (height_q < HeightFloor) begin
      height_eff = HeightFloor;
    end else if (height_q > HeightLimit) begin
      height_eff = HeightLimit;
    end else begin
      height_eff = height_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= WidthReset;
      height_q <= HeightReset;
    end else if (wr_fire) begin
      case (wr_idx)
        REG_FRAME_WIDTH:  width_q  <= pwdata[WidthW-1:0];
        REG_FRAME_HEIGHT: height_q <= pwdata[HeightW-1:0];
        default:          width_q  <= width_q;
      endcase
    end
  end

  // first cell of the bottom row; a stale registered value is harmless since
  // the sweep starts at cell zero, which never lies in the bottom row
  always_ff @(posedge clk_i) begin
    base_q <= AddrW'(RowW'(height_eff - HeightW'(1)) * width_eff);
  end

  assign top       = {1'b0, base_q} + (AddrW+1)'(width_eff);
  assign in_bottom = (clr_addr_q >= base_q) && ({1'b0, clr_addr_q} < top);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_active_q <= 1'b1;
      clr_addr_q   <= '0;
    end else if (wr_fire) begin
      clr_active_q <= 1'b1;
      clr_addr_q   <= '0;
    end else if (clr_active_q) begin
      clr_addr_q <= clr_addr_q + AddrW'(1);
      if (clr_addr_q == AddrW'(StoreDepth - 1)) begin
        clr_active_q <= 1'b0;
      end
    end
  end

  assign clr_o.en   = clr_active_q;
  assign clr_o.addr = clr_addr_q;
  assign clr_o.heat = in_bottom ? HeatMax : '0;

  assign cfg_o.width    = width_eff;
  assign cfg_o.height   = height_eff;
  assign cfg_o.clearing = clr_active_q;

endmodule

FILE: design/fecu_scan.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fecu_scan
// Scan position counters and source / target address generation.
// ----------------------------------------------------------------------------
module fecu_scan
  import fecu_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  cfg_t             cfg_i,
  input  logic             accept_i,
  input  logic [PickW-1:0] pick_i,
  output scan_item_t       item_o
);

  logic [ColW-1:0]    col_q;
  logic [RowW-1:0]    row_q;
  logic [AddrW-1:0]   src_q;
  logic [AddrW+1:0]   t_val;
  logic               last_row;
  logic               last_col;
  logic [AddrW-1:0]   w_addr;

  assign w_addr   = AddrW'(cfg_i.width);
  assign last_row = !(({1'b0, row_q} + HeightW'(1)) < cfg_i.height);
  assign last_col = !(({1'b0, col_q} + WidthW'(1)) < cfg_i.width);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q <= '0;
      row_q <= RowW'(1);
      src_q <= AddrW'(WidthReset);
    end else if (cfg_i.clearing) begin
      col_q <= '0;
      row_q <= RowW'(1);
      src_q <= w_addr;
    end else if (accept_i) begin
      if (!last_row) begin
        row_q <= row_q + RowW'(1);
        src_q <= src_q + w_addr;
      end else if (!last_col) begin
        row_q <= RowW'(1);
        col_q <= col_q + ColW'(1);
        src_q <= w_addr + AddrW'(col_q) + AddrW'(1);
      end else begin
        row_q <= RowW'(1);
        col_q <= '0;
        src_q <= w_addr;
      end
    end
  end

  // target one row up, drifted by one minus the pick
  assign t_val = {2'b00, src_q} + (AddrW+2)'(1) - (AddrW+2)'(pick_i);

  always_comb begin
    item_o.src = src_q;
    if ($signed(t_val) < $signed((AddrW+2)'(cfg_i.width))) begin
      item_o.dst = '0;
    end else begin
      item_o.dst = AddrW'(t_val - (AddrW+2)'(cfg_i.width));
    end
    item_o.done = last_row && last_col;
  end

endmodule

FILE: design/fecu_update.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fecu_update
// Heat decay stage, heat write-back, palette lookup and output register.
// ----------------------------------------------------------------------------
module fecu_update
  import fecu_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             accept_i,
  input  scan_item_t       item_i,
  input  logic [PickW-1:0] pick_i,
  input  logic [HeatW-1:0] rd_data_i,
  output logic             s1_free_o,
  output heat_wr_t         wr_o,
  output logic             m_valid_o,
  input  logic             m_ready_i,
  output logic [95:0]      m_data_o,
  output logic             m_last_o
);

  logic             s1_valid_q;
  scan_item_t       s1_item_q;
  logic             s1_decay_q;
  logic             s1_fwd_q;
  logic [HeatW-1:0] s1_fwd_heat_q;
  logic             s1_adv;
  logic [HeatW-1:0] raw_heat;
  logic [HeatW-1:0] src_heat;
  logic [HeatW-1:0] dst_heat;
  logic [HeatW-1:0] src_after;
  logic             out_valid_q;
  logic [95:0]      out_data_q;
  logic             out_last_q;

  assign s1_adv    = s1_valid_q && (!out_valid_q || m_ready_i);
  assign s1_free_o = !s1_valid_q || s1_adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (s1_free_o) begin
      s1_valid_q <= accept_i;
    end
  end

  // forward the heat written in the same cycle as the new read
  always_ff @(posedge clk_i) begin
    if (accept_i) begin
      s1_item_q     <= item_i;
      s1_decay_q    <= pick_i[0];
      s1_fwd_q      <= s1_adv && (s1_item_q.dst == item_i.src);
      s1_fwd_heat_q <= dst_heat;
    end
  end

  always_comb begin
    raw_heat = s1_fwd_q ? s1_fwd_heat_q : rd_data_i;
    src_heat = (raw_heat > HeatMax) ? '0 : raw_heat;
    if (s1_decay_q && (src_heat == '0)) begin
      dst_heat = '0;
    end else begin
      dst_heat = src_heat - HeatW'(s1_decay_q);
    end
    src_after = (s1_item_q.dst == s1_item_q.src) ? dst_heat : src_heat;
  end

  assign wr_o.en   = s1_adv;
  assign wr_o.addr = s1_item_q.dst;
  assign wr_o.heat = dst_heat;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (s1_adv) begin
      out_valid_q <= 1'b1;
    end else if (m_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_adv) begin
      out_data_q <= {6'b0,
                     pal_bg(src_after), pal_fg(src_after), pal_glyph(src_after),
                     s1_item_q.src,
                     pal_bg(dst_heat), pal_fg(dst_heat), pal_glyph(dst_heat),
                     s1_item_q.dst};
      out_last_q <= s1_item_q.done;
    end
  end

  assign m_valid_o = out_valid_q;
  assign m_data_o  = out_data_q;
  assign m_last_o  = out_last_q;

endmodule

FILE: design/fire_effect_cell_update_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fire_effect_cell_update_unit
// Fire effect heat map updater built around one heat memory.
// ----------------------------------------------------------------------------
// Usage:
//   Each transaction on the s_axis channel carries a random pick and moves
//   the scan on by one cell (columns outer, rows 1 and up inner). Each cell
//   yields one transaction on m_axis with the target and source addresses,
//   their palette entries, and tlast on the last cell of a frame.
//   The heat memory read data and the update stage register at the input
//   transaction, and the update stage loads the output register once that
//   register is empty or its result is being taken on m_axis.
//   Throughput: one cell per cycle while m_axis takes results and no sweep
//   runs, set by the heat memory doing one read and one write each cycle; a
//   write that lands on the cell being read in the same cycle is forwarded.
//   Reset and every register write start a clearing sweep over all 32768
//   memory cells, loading the bottom row with full heat; the input stays
//   not ready during the sweep and the scan restarts.
//   When m_axis stalls, the output register holds its result and one more
//   cell can enter the update stage; then s_axis_tready drops.
//   Registers (APB): 0x0 frame_width, 0x4 frame_height. Write while idle.
// ----------------------------------------------------------------------------
module fire_effect_cell_update_unit
  import fecu_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [1:0] random_pick
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // [14:0] dst_addr, [28:15] dst_glyph, [36:29] dst_fg, [44:37] dst_bg,
  // [59:45] src_addr, [73:60] src_glyph, [81:74] src_fg, [89:82] src_bg
  output logic [95:0] m_axis_tdata,
  output logic        m_axis_tlast,   // frame_done
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  cfg_t             cfg;
  heat_wr_t         clr_wr;
  heat_wr_t         upd_wr;
  heat_wr_t         ram_wr;
  scan_item_t       item;
  logic             s1_free;
  logic             accept;
  logic [HeatW-1:0] rd_data;
  logic [PickW-1:0] pick;

  assign pick          = s_axis_tdata[PickW-1:0];
  assign s_axis_tready = !cfg.clearing && s1_free;
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign ram_wr        = cfg.clearing ? clr_wr : upd_wr;

  fecu_cfg u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg),
    .clr_o   (clr_wr)
  );

  fecu_scan u_scan (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .cfg_i    (cfg),
    .accept_i (accept),
    .pick_i   (pick),
    .item_o   (item)
  );

  fecu_heat_ram u_ram (
    .clk_i     (clk_i),
    .wr_i      (ram_wr),
    .rd_en_i   (accept),
    .rd_addr_i (item.src),
    .rd_data_o (rd_data)
  );

  fecu_update u_update (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .accept_i  (accept),
    .item_i    (item),
    .pick_i    (pick),
    .rd_data_i (rd_data),
    .s1_free_o (s1_free),
    .wr_o      (upd_wr),
    .m_valid_o (m_axis_tvalid),
    .m_ready_i (m_axis_tready),
    .m_data_o  (m_axis_tdata),
    .m_last_o  (m_axis_tlast)
  );

endmodule

FILE: design/fecu_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fecu_checker
// Port-level checks of the fire cell updater, bound to the top level.
// ----------------------------------------------------------------------------
module fecu_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tready,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [95:0] m_axis_tdata,
  input logic        m_axis_tlast,
  input logic        psel,
  input logic        penable,
  input logic        pwrite
);

  // hold a stalled result
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast))
    else $error("stalled result changed");

  // a register write restarts the clearing sweep
  a_cfg_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    psel && penable && pwrite |=> !s_axis_tready)
    else $error("input ready right after a register write");

  // the target address never exceeds the source address
  a_dst_below: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> m_axis_tdata[14:0] <= m_axis_tdata[59:45])
    else $error("target address above source");

  // zero heat maps to a space on a grey foreground
  a_pal_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> ((m_axis_tdata[28:15] == 14'd32) == (m_axis_tdata[36:29] == 8'd16)))
    else $error("target palette entry inconsistent");

endmodule

bind fire_effect_cell_update_unit fecu_checker u_fecu_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tlast  (m_axis_tlast),
  .psel          (psel),
  .penable       (penable),
  .pwrite        (pwrite)
);
